### src/ssms_pkg.sv
package ssms_pkg;

   localparam int MAX_LEN = 1024;
   localparam int ADDR_W  = $clog2(MAX_LEN);
   localparam int COUNT_W = $clog2(MAX_LEN + 1);
   localparam int PRICE_W = 32;
   localparam int SPAN_W  = 11;

   typedef struct packed {
      logic signed [PRICE_W-1:0] price;
      logic [ADDR_W-1:0]         pos;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [SPAN_W-1:0] span;
      logic              overflow;
      logic              last;
   } result_type;

endpackage

### src/ssms_ram.sv
module ssms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/ssms_seq.sv
module ssms_seq
   import ssms_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic signed [PRICE_W-1:0] in_price,
   input  logic                      in_last,
   output logic                      res_valid,
   input  logic                      res_ready,
   output result_type                res
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]                state_ff, state_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [COUNT_W-1:0]        pos_ff, pos_in;
   logic signed [PRICE_W-1:0] price_ff, price_in;
   logic                      last_ff, last_in;
   result_type                res_ff, res_in;

   logic                      wr_en;
   logic [ADDR_W-1:0]         wr_addr;
   entry_type                 wr_entry;
   logic [ADDR_W-1:0]         rd_addr;
   logic [ENTRY_W-1:0]        rd_data;
   entry_type                 top_entry;
   logic [COUNT_W-1:0]        rd_index;

   // compare: stack top against the current price
   logic                      top_pop;
   logic [COUNT_W-1:0]        top_dist;

   ssms_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_LEN)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign top_entry = entry_type'(rd_data);
   assign top_pop   = (top_entry.price <= price_ff);
   assign top_dist  = pos_ff - {{(COUNT_W-ADDR_W){1'b0}}, top_entry.pos};

   // always fetch the entry that will be on top next cycle
   assign rd_index = count_in - COUNT_W'(1);
   assign rd_addr  = rd_index[ADDR_W-1:0];

   assign wr_entry.pos   = pos_ff[ADDR_W-1:0];
   assign wr_entry.price = price_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      price_in = price_ff;
      last_in  = last_ff;
      res_in   = res_ff;
      wr_en    = 1'b0;
      wr_addr  = count_ff[ADDR_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               price_in = in_price;
               last_in  = in_last;
               if (pos_ff == COUNT_W'(MAX_LEN)) begin
                  res_in.span     = '0;
                  res_in.overflow = 1'b1;
                  res_in.last     = in_last;
                  if (in_last) begin
                     count_in = '0;
                     pos_in   = '0;
                  end
                  state_in = S_DONE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            res_in.overflow = 1'b0;
            res_in.last     = last_ff;
            if (count_ff == '0) begin
               res_in.span = SPAN_W'(pos_ff + COUNT_W'(1));
               wr_en       = 1'b1;
               count_in    = count_ff + COUNT_W'(1);
               pos_in      = pos_ff + COUNT_W'(1);
               state_in    = S_DONE;
            end else if (top_pop) begin
               count_in = count_ff - COUNT_W'(1);
            end else begin
               res_in.span = SPAN_W'(top_dist);
               wr_en       = 1'b1;
               count_in    = count_ff + COUNT_W'(1);
               pos_in      = pos_ff + COUNT_W'(1);
               state_in    = S_DONE;
            end
            if (state_in == S_DONE && last_ff) begin
               count_in = '0;
               pos_in   = '0;
            end
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pos_ff   <= pos_in;
      end
      price_ff <= price_in;
      last_ff  <= last_in;
      res_ff   <= res_in;
   end

   assign in_ready  = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res       = res_ff;

endmodule

### src/stock_span_monotonic_stack_top.sv
// stock span unit: for each signed price it returns the count of consecutive
// prices up to and including it that are less than or equal to it.
// input channel req_: tdata carries the price, tlast ends a series; after a
// transfer with tlast the next price starts a new series at position 0.
// result channel rsp_: one transfer per input transfer, in order. tdata holds
// the span, tuser flags an item beyond 1024 items of its series (span 0),
// tlast copies the input tlast.
// an item goes through the idle, read and done states, staying in read while
// it pops stack entries (an overflowed item skips read); the stack memory is
// read one entry per cycle through its registered port while the sequencer
// compares that entry against the price. pops amortize to one per item.
// req_tready is high only while the sequencer is idle.
// the result sits in an output register, so the next item is taken while a
// result waits; if the receiver stalls further, the sequencer holds the
// following result and stops taking input until the register frees.
// reset clears the stack and the position; the stack memory needs no clearing.
module stock_span_monotonic_stack_top
   import ssms_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // price[31:0]
   input  logic        req_tlast,   // last_in_series
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // span[10:0], zero fill [15:11]
   output logic        rsp_tuser,   // overflow
   output logic        rsp_tlast    // last_out
);

   logic       res_valid;
   logic       res_ready;
   result_type res;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   ssms_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_price  (req_tdata),
      .in_last   (req_tlast),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(16-SPAN_W){1'b0}}, rsp_ff.span};
   assign rsp_tuser  = rsp_ff.overflow;
   assign rsp_tlast  = rsp_ff.last;

endmodule

### dv/stock_span_monotonic_stack_top_tb.sv
module stock_span_monotonic_stack_top_tb;
   import ssms_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int RANDOM_ITEMS = 60;

   typedef enum int {PAT_NOISE, PAT_FLAT, PAT_RISE, PAT_FALL, PAT_WALK} price_pattern_type;

   typedef struct {
      logic signed [PRICE_W-1:0] price;
      logic                      last;
      bit                        drain;   // hold until all spans are back
   } price_item_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // price[31:0]
   logic        req_tlast = 1'b0; // last_in_series
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // span[10:0], zero fill [15:11]
   logic        rsp_tuser;        // overflow
   logic        rsp_tlast;        // last_out

   stock_span_monotonic_stack_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   price_item_type price_q[$];
   result_type     span_q[$];

   // predictor state: stack of still-greater prices and their positions
   logic signed [PRICE_W-1:0] stk_price[MAX_LEN];
   int                        stk_pos[MAX_LEN];
   int                        stk_depth = 0;
   int                        series_pos = 0;

   int n_total = 0;
   int n_sent = 0;
   int n_checked = 0;
   int n_overflow = 0;
   int n_series = 0;
   int max_span = 0;
   int err_count = 0;
   int cycles = 0;

   int gap_left = 0;
   int send_calm = 0;
   int rsp_wait = 0;
   int recv_calm = 0;
   result_type want;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0d: %s", cycles, msg);
      err_count++;
   endtask

   function automatic int draw_wait(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         calm_left = $urandom_range(8, 60);
         return 0;
      end
      return $urandom_range(0, 17);
   endfunction

   function automatic result_type predict_span(logic signed [PRICE_W-1:0] price, logic last);
      result_type r;
      r.span = '0;
      r.overflow = 1'b0;
      r.last = last;
      if (series_pos >= MAX_LEN) begin
         r.overflow = 1'b1;
         series_pos = MAX_LEN;
      end else begin
         // equal earlier prices are popped and count toward the span
         while (stk_depth > 0 && stk_price[stk_depth-1] <= price)
            stk_depth--;
         if (stk_depth == 0)
            r.span = SPAN_W'(series_pos + 1);
         else
            r.span = SPAN_W'(series_pos - stk_pos[stk_depth-1]);
         if (stk_depth < MAX_LEN) begin
            stk_price[stk_depth] = price;
            stk_pos[stk_depth] = series_pos;
            stk_depth++;
         end
         series_pos++;
      end
      if (last) begin
         stk_depth = 0;
         series_pos = 0;
      end
      return r;
   endfunction

   task automatic add_item(input logic signed [PRICE_W-1:0] price, input logic last,
                           input bit drain = 1'b0);
      price_item_type it;
      it.price = price;
      it.last = last;
      it.drain = drain;
      price_q.insert(price_q.size(), it);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tlast <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            void'(price_q.pop_front());
            n_sent++;
            gap_left = draw_wait(send_calm);
         end
         if (req_tvalid && !req_tready) begin
            // hold the current transfer
         end else if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (price_q.size() > 0 && (!price_q[0].drain || n_sent == n_checked)) begin
            req_tvalid <= 1'b1;
            req_tdata <= price_q[0].price;
            req_tlast <= price_q[0].last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor: predicts on each input transfer, checks each result transfer
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (req_tvalid && req_tready)
            span_q.insert(span_q.size(), predict_span(req_tdata, req_tlast));
         if (rsp_tvalid && rsp_tready) begin
            if (span_q.size() == 0) begin
               report_mismatch("result transfer with no span expected");
            end else begin
               want = span_q.pop_front();
               n_checked++;
               if (rsp_tdata !== {5'b0, want.span})
                  report_mismatch($sformatf("result %0d: span 0x%0h, expected %0d",
                                            n_checked, rsp_tdata, want.span));
               if (rsp_tuser !== want.overflow)
                  report_mismatch($sformatf("result %0d: overflow %b, expected %b",
                                            n_checked, rsp_tuser, want.overflow));
               if (rsp_tlast !== want.last)
                  report_mismatch($sformatf("result %0d: last %b, expected %b",
                                            n_checked, rsp_tlast, want.last));
               if (want.overflow)
                  n_overflow++;
               if (want.last)
                  n_series++;
               if (int'(want.span) > max_span)
                  max_span = int'(want.span);
            end
            rsp_wait = draw_wait(recv_calm);
         end else if (rsp_wait > 0) begin
            rsp_wait--;
         end
         rsp_tready <= (rsp_wait == 0);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d of %0d spans checked",
                  cycles, n_checked, n_total);
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int i, len, n_rand;
      bit end_series;
      price_pattern_type pattern;
      logic signed [PRICE_W-1:0] cur, p;

      // single-item series
      add_item(32'sd42, 1'b1);
      // textbook series, spans 1 1 1 2 1 4 6
      add_item(32'sd100, 1'b0);
      add_item(32'sd80, 1'b0);
      add_item(32'sd60, 1'b0);
      add_item(32'sd70, 1'b0);
      add_item(32'sd60, 1'b0);
      add_item(32'sd75, 1'b0);
      add_item(32'sd85, 1'b1);
      // extremes of the price and runs of equal prices
      add_item(32'sh8000_0000, 1'b0);
      add_item(32'sh7fff_ffff, 1'b0);
      add_item(32'sh7fff_ffff, 1'b0);
      add_item(32'sh8000_0000, 1'b0);
      add_item(-32'sd1, 1'b0);
      add_item(32'sd0, 1'b0);
      add_item(32'sd0, 1'b0);
      add_item(32'sd1, 1'b0);
      add_item(32'sh8000_0000, 1'b0);
      add_item(32'sh7fff_ffff, 1'b1);
      add_item(-32'sd5, 1'b1);

      // falling series fills the stack, the top price at the last position
      // empties it for span 1024, then the series runs past the maximum length
      for (i = 0; i < MAX_LEN - 1; i++)
         add_item(PRICE_W'(1000000 - i), 1'b0, i == 0);
      add_item(32'sh7fff_ffff, 1'b0);
      add_item(32'sh7fff_ffff, 1'b0);
      add_item(32'sh8000_0000, 1'b1);
      // a fresh series after an overflowed end
      add_item(32'sd3, 1'b0, 1'b1);
      add_item(32'sd3, 1'b0);
      add_item(32'sd3, 1'b1);

      n_rand = 0;
      cur = '0;
      while (n_rand < RANDOM_ITEMS) begin
         len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
         if (len > RANDOM_ITEMS - n_rand)
            len = RANDOM_ITEMS - n_rand;
         pattern = price_pattern_type'($urandom_range(0, 4));
         end_series = ($urandom_range(0, 7) != 0);
         if ($urandom_range(0, 1) == 0)
            cur = $urandom;
         for (i = 0; i < len; i++) begin
            case (pattern)
               PAT_NOISE: p = $urandom;
               PAT_FLAT: p = PRICE_W'($urandom_range(0, 6)) - 32'sd3;
               PAT_RISE: begin
                  cur = cur + PRICE_W'($urandom_range(0, 3));
                  p = cur;
               end
               PAT_FALL: begin
                  cur = cur - PRICE_W'($urandom_range(0, 3));
                  p = cur;
               end
               default: begin
                  cur = cur + PRICE_W'($urandom_range(0, 8)) - 32'sd4;
                  p = ($urandom_range(0, 19) == 0) ? {$urandom_range(0, 1) == 0, {31{1'b1}}} ^
                      32'sh8000_0000 : cur;
               end
            endcase
            add_item(p, end_series && i == len - 1, $urandom_range(0, 150) == 0);
         end
         n_rand += len;
      end
      // leave the predictor and the block with no open series
      add_item($urandom, 1'b1);
      n_total = price_q.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      wait (n_sent == n_total);
      wait (n_checked == n_total);
      repeat (20) @(posedge clock);

      $display("checked %0d spans over %0d series in %0d cycles", n_checked, n_series, cycles);
      $display("overflowed items: %0d, largest span: %0d, mismatches: %0d",
               n_overflow, max_span, err_count);
      if (err_count == 0 && span_q.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
